// ----- rtl/sync_checksum_frame_finder_unit_macros.svh -----
// Assertion macros used by the checker file.
`ifndef SYNC_CHECKSUM_FRAME_FINDER_UNIT_MACROS_SVH
`define SYNC_CHECKSUM_FRAME_FINDER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define SCCF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define SCCF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/sccf_pkg.sv -----
package sccf_pkg;

   localparam int WinLen    = 7;
   localparam int FillWidth = 3;

   typedef logic [7:0]           byte_type;
   typedef logic [FillWidth-1:0] fill_type;

   localparam byte_type SyncByte = 8'hAA;
   localparam fill_type FillFull = fill_type'(WinLen);

   typedef struct packed {
      byte_type    command_code;
      logic [31:0] payload_word;
      byte_type    extra_byte;
   } rsp_fields_type;

endpackage

// ----- rtl/sync_checksum_frame_finder_unit.sv -----
// channel | direction | ports
// --------+-----------+-------------------------------------------------------
// req     | in        | req_valid, req_stall, req_rx_byte
// rsp     | out       | rsp_valid, rsp_stall, rsp_command_code,
//         |           | rsp_payload_word, rsp_extra_byte
//
// One request per cycle while req_stall is low; a frame shows on rsp in the cycle
// after its checksum byte is taken, from the output register.
// The seven window cells feed a combinational add chain.
// Reset (synchronous) clears the fill count and the output valid flag.
// req_stall is high only while a held result sees rsp_stall high.
module sync_checksum_frame_finder_unit
   import sccf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_command_code,
   output logic [31:0] rsp_payload_word,
   output logic [7:0]  rsp_extra_byte
);

   byte_type       cell_data [WinLen];
   byte_type       cell_sum  [WinLen+1];
   fill_type       fill_ff;
   fill_type       fill_in;
   logic           accept;
   logic           hit;
   rsp_fields_type frame_fields;
   rsp_fields_type out_fields;

   assign req_stall = rsp_valid & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign cell_sum[0] = '0;

   for (genvar k = 0; k < WinLen; k++) begin : g_cell
      byte_type shift_in;
      if (k == WinLen - 1) begin : g_tail
         assign shift_in = req_rx_byte;
      end else begin : g_body
         assign shift_in = cell_data[k+1];
      end
      sccf_cell u_cell (
         .clock    (clock),
         .shift_en (accept),
         .shift_in (shift_in),
         .sum_in   (cell_sum[k]),
         .data_out (cell_data[k]),
         .sum_out  (cell_sum[k+1])
      );
   end

   assign hit = (fill_ff == FillFull) && (cell_data[0] == SyncByte)
                && (cell_sum[WinLen] == req_rx_byte);

   always_comb begin
      frame_fields.command_code = cell_data[1];
      frame_fields.payload_word = {cell_data[5], cell_data[4], cell_data[3], cell_data[2]};
      frame_fields.extra_byte   = cell_data[6];
   end

   always_comb begin
      fill_in = fill_ff;
      if (accept) begin
         priority if (hit) begin
            fill_in = '0;
         end else if (fill_ff != FillFull) begin
            fill_in = fill_ff + fill_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   sccf_resp u_resp (
      .clock       (clock),
      .reset       (reset),
      .load_en     (accept & hit),
      .load_fields (frame_fields),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_fields  (out_fields)
   );

   assign rsp_command_code = out_fields.command_code;
   assign rsp_payload_word = out_fields.payload_word;
   assign rsp_extra_byte   = out_fields.extra_byte;

endmodule

// ----- rtl/sccf_cell.sv -----
module sccf_cell
   import sccf_pkg::*;
(
   input  logic     clock,
   input  logic     shift_en,
   input  byte_type shift_in,
   input  byte_type sum_in,
   output byte_type data_out,
   output byte_type sum_out
);

   byte_type byte_ff;
   byte_type byte_in;

   assign byte_in  = shift_en ? shift_in : byte_ff;
   assign data_out = byte_ff;
   // running checksum, wraps at 8 bits
   assign sum_out  = sum_in + byte_ff;

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

endmodule

// ----- rtl/sccf_resp.sv -----
module sccf_resp
   import sccf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           load_en,
   input  rsp_fields_type load_fields,
   input  logic           rsp_stall,
   output logic           rsp_valid,
   output rsp_fields_type rsp_fields
);

   logic           valid_ff;
   logic           valid_in;
   rsp_fields_type fields_ff;
   rsp_fields_type fields_in;

   always_comb begin
      valid_in  = valid_ff & rsp_stall;
      fields_in = fields_ff;
      if (load_en) begin
         valid_in  = 1'b1;
         fields_in = load_fields;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fields_ff <= fields_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_fields = fields_ff;

endmodule

// ----- rtl/sccf_checker.sv -----
`include "sync_checksum_frame_finder_unit_macros.svh"

module sccf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_rx_byte,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_command_code,
   input logic [31:0] rsp_payload_word,
   input logic [7:0]  rsp_extra_byte
);

   `SCCF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_command_code) && $stable(rsp_payload_word) && $stable(rsp_extra_byte), "stalled result changed")
   `SCCF_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall, req_valid && $stable(req_rx_byte), "stalled request changed")
   `SCCF_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall, "request stalled without a blocked result")
   `SCCF_ASSERT_NOW(a_rise_needs_req, clock, reset, $rose(rsp_valid), $past(req_valid && !req_stall), "result appeared without an accepted request")
   `SCCF_ASSERT_NEXT(a_refill_needs_req, clock, reset, rsp_valid && !rsp_stall, !rsp_valid || $past(req_valid && !req_stall), "result repeated without a new request")

endmodule

bind sync_checksum_frame_finder_unit sccf_checker u_sccf_checker (.*);
